[rtl/core/mtu_pkg.sv]
// Shared types, constants and fixed-point helpers of the matrix transform unit.
`default_nettype none
package mtu_pkg;
    localparam int DataWidth = 32;
    localparam int FracBits  = 12;
    localparam int NumElem   = 16;
    localparam logic signed [DataWidth-1:0] FracOne = 32'sd4096;

    typedef logic signed [DataWidth-1:0] word_t;
    typedef logic [3:0] action_t;

    localparam action_t ActIdentity  = 4'd0;
    localparam action_t ActWrCur     = 4'd1;
    localparam action_t ActWrOperand = 4'd2;
    localparam action_t ActMultiply  = 4'd3;
    localparam action_t ActTranslate = 4'd4;
    localparam action_t ActScale     = 4'd5;
    localparam action_t ActXform4    = 4'd6;
    localparam action_t ActXform3    = 4'd7;
    localparam action_t ActTranspose = 4'd8;
    localparam action_t ActRead      = 4'd9;

    // Product shifted right arithmetically, kept at 52 bits
    function automatic logic signed [51:0] fmul(input word_t a, input word_t b);
        logic signed [63:0] p;
        begin
            p = 64'(a) * 64'(b);
            fmul = 52'(p >>> FracBits);
        end
    endfunction

    function automatic word_t sat32(input logic signed [53:0] v);
        begin
            if (v > 54'sh0_7FFF_FFFF)
                sat32 = 32'sh7FFF_FFFF;
            else if (v < -54'sh0_8000_0000)
                sat32 = 32'sh8000_0000;
            else
                sat32 = v[31:0];
        end
    endfunction
endpackage
`default_nettype wire

[rtl/core/mtu_dot4.sv]
// Four-term fixed-point dot product lane with saturation.
`default_nettype none
module mtu_dot4
    import mtu_pkg::*;
(
    input  word_t a0, input word_t a1, input word_t a2, input word_t a3,
    input  word_t b0, input word_t b1, input word_t b2, input word_t b3,
    input  word_t bias,
    output word_t sum
);
    logic signed [53:0] total;
    always_comb
    begin
        total = 54'(fmul(a0, b0)) + 54'(fmul(a1, b1)) + 54'(fmul(a2, b2))
              + 54'(fmul(a3, b3)) + 54'(bias);
        sum = sat32(total);
    end
endmodule
`default_nettype wire

[rtl/core/matrix_transform_unit.sv]
// Top level of the 4x4 fixed-point matrix transform unit.
`default_nettype none
// One command word is accepted per cycle unless the skid stage is full; the
// dot-product units are combinational between the input and the matrix/result
// registers. Transforms and reads produce one four-word result held in an
// output register, with a skid stage so input is taken while a result waits.
// Values are signed Q19.12; sums saturate to 32 bits. Operand elements must be
// written before a multiply reads them.
module matrix_transform_unit
    import mtu_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    in_valid,
    output logic         in_ready,
    input  wire action_t action,
    input  wire logic [3:0] elem_index,
    input  wire word_t   elem_value,
    input  wire word_t   vx,
    input  wire word_t   vy,
    input  wire word_t   vz,
    input  wire word_t   vw,
    output logic         out_valid,
    input  wire logic    out_ready,
    output word_t        rx,
    output word_t        ry,
    output word_t        rz,
    output word_t        rw
);
    word_t cur_reg [NumElem];
    word_t cur_next [NumElem];
    word_t opd_reg [NumElem];
    word_t lane [4];
    word_t la [4][4];
    word_t lb [4][4];
    word_t lbias [4];
    word_t v [4];
    logic  acc;

    // Result buffer (0) and skid (1)
    word_t res_reg [2][4];
    logic [1:0] rv_reg;
    word_t res_new [4];
    logic res_fire;

    assign v[0] = vx;
    assign v[1] = vy;
    assign v[2] = vz;
    assign v[3] = vw;
    assign in_ready = ~rv_reg[1];
    assign acc = in_valid & in_ready;

    // Multiply uses column selected by elem_index? No: multiply needs all 16;
    // use lanes for transform/translate, separate logic for multiply columns.
    always_comb
    begin
        for (int r = 0; r < 4; r++)
        begin
            lbias[r] = '0;
            for (int k = 0; k < 4; k++)
            begin
                la[r][k] = cur_reg[k*4+r];
                lb[r][k] = '0;
            end
            case (action)
                ActXform4:
                    for (int k = 0; k < 4; k++) lb[r][k] = v[k];
                ActXform3:
                    if (r < 3)
                        for (int k = 0; k < 3; k++) lb[r][k] = v[k];
                ActTranslate:
                begin
                    for (int k = 0; k < 3; k++) lb[r][k] = v[k];
                    lbias[r] = cur_reg[12+r];
                end
                default: ;
            endcase
        end
    end

    genvar g, c;
    generate
        for (g = 0; g < 4; g++)
        begin : g_lane
            mtu_dot4 u_dot (
                .a0(la[g][0]), .a1(la[g][1]), .a2(la[g][2]), .a3(la[g][3]),
                .b0(lb[g][0]), .b1(lb[g][1]), .b2(lb[g][2]), .b3(lb[g][3]),
                .bias(lbias[g]), .sum(lane[g])
            );
        end
    endgenerate

    // Matrix product columns
    word_t prod [NumElem];
    generate
        for (c = 0; c < 4; c++)
        begin : g_col
            for (g = 0; g < 4; g++)
            begin : g_row
                mtu_dot4 u_mm (
                    .a0(cur_reg[g]), .a1(cur_reg[4+g]), .a2(cur_reg[8+g]),
                    .a3(cur_reg[12+g]),
                    .b0(opd_reg[c*4]), .b1(opd_reg[c*4+1]), .b2(opd_reg[c*4+2]),
                    .b3(opd_reg[c*4+3]), .bias('0), .sum(prod[c*4+g])
                );
            end
        end
    endgenerate

    always_comb
    begin
        for (int i = 0; i < NumElem; i++) cur_next[i] = cur_reg[i];
        unique case (action)
            ActIdentity:
                for (int i = 0; i < NumElem; i++)
                    cur_next[i] = (i % 5 == 0) ? FracOne : '0;
            ActWrCur:     cur_next[elem_index] = elem_value;
            ActMultiply:  for (int i = 0; i < NumElem; i++) cur_next[i] = prod[i];
            ActTranslate: for (int r = 0; r < 4; r++) cur_next[12+r] = lane[r];
            ActScale:
                for (int i = 0; i < 12; i++)
                    cur_next[i] = sat32(54'(fmul(cur_reg[i], v[i/4])));
            ActTranspose:
                for (int i = 0; i < NumElem; i++)
                    cur_next[i] = cur_reg[(i%4)*4 + i/4];
            default: ;
        endcase
    end

    always_comb
    begin
        res_fire = acc & (action == ActXform4 || action == ActXform3 || action == ActRead);
        for (int r = 0; r < 4; r++) res_new[r] = lane[r];
        if (action == ActRead)
        begin
            res_new[0] = cur_reg[elem_index];
            res_new[1] = '0;
            res_new[2] = '0;
            res_new[3] = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NumElem; i++)
                cur_reg[i] <= (i % 5 == 0) ? FracOne : '0;
        end
        else if (acc)
        begin
            for (int i = 0; i < NumElem; i++) cur_reg[i] <= cur_next[i];
        end
    end

    always_ff @(posedge clk)
    begin
        if (acc && action == ActWrOperand) opd_reg[elem_index] <= elem_value;
    end

    // Output queue of depth two
    logic pop;
    assign pop = rv_reg[0] & out_ready;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rv_reg <= '0;
        else
        begin
            unique case ({res_fire, pop})
                2'b10: rv_reg <= {rv_reg[0], 1'b1};
                2'b01: rv_reg <= {1'b0, rv_reg[1]};
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            if (rv_reg[1]) res_reg[0] <= res_reg[1];
            else if (res_fire) res_reg[0] <= res_new;
        end
        else if (res_fire)
        begin
            if (rv_reg[0]) res_reg[1] <= res_new;
            else res_reg[0] <= res_new;
        end
        if (pop && rv_reg[1] && res_fire) res_reg[1] <= res_new;
    end

    assign out_valid = rv_reg[0];
    assign rx = res_reg[0][0];
    assign ry = res_reg[0][1];
    assign rz = res_reg[0][2];
    assign rw = res_reg[0][3];
endmodule
`default_nettype wire

[rtl/core/mtu_checker.sv]
// Port-level checker for the matrix transform unit, bound to the top level.
`default_nettype none
module mtu_checker
    import mtu_pkg::*;
(
    input wire logic clk,
    input wire logic rst_n,
    input wire logic in_valid,
    input wire logic in_ready,
    input wire action_t action,
    input wire logic out_valid,
    input wire logic out_ready,
    input wire word_t rx,
    input wire word_t ry,
    input wire word_t rz,
    input wire word_t rw
);
    a_read_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && action == ActRead |=> out_valid)
        else $error("read gave no result");
    a_xform_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (action == ActXform4 || action == ActXform3) |=> out_valid)
        else $error("transform gave no result");
    a_read_zero: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && action == ActRead && !out_valid |=> ry == 0 && rz == 0 && rw == 0)
        else $error("read result not zero-padded");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(rx))
        else $error("result dropped while stalled");
endmodule

bind matrix_transform_unit mtu_checker u_mtu_checker (.*);
`default_nettype wire
